### hw/rtl/kfsl_pkg.sv
package kfsl_pkg;

  localparam int FRAME_W     = 31;
  localparam int KIND_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int COUNT_OUT_W = 11;

  localparam int MAX_KEYS_DEF = 1024;

  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

  typedef struct packed {
    logic               start;
    logic [FRAME_W-1:0] query;
  } srch_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [FRAME_W-1:0] target;
  } srch_rsp_t;

endpackage

### hw/rtl/kfsl_key_mem.sv
module kfsl_key_mem #(
  parameter int DEPTH = kfsl_pkg::MAX_KEYS_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [kfsl_pkg::FRAME_W-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr,
  output logic [kfsl_pkg::FRAME_W-1:0] rd_data
);

  logic [kfsl_pkg::FRAME_W-1:0] mem [DEPTH];
  logic [kfsl_pkg::FRAME_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/kfsl_search.sv
module kfsl_search #(
  parameter int MAX_KEYS = kfsl_pkg::MAX_KEYS_DEF,
  localparam int AW = $clog2(MAX_KEYS),
  localparam int CW = $clog2(MAX_KEYS + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  kfsl_pkg::srch_req_t          req,
  input  logic [CW-1:0]                key_count,
  output logic [AW-1:0]                rd_addr,
  input  logic [kfsl_pkg::FRAME_W-1:0] rd_data,
  output kfsl_pkg::srch_rsp_t          rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADDR = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_ECHO = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [AW-1:0]                mid_r, mid_nxt;
  logic [kfsl_pkg::FRAME_W-1:0] q_r, q_nxt;

  logic [CW:0]   sum;
  logic [AW-1:0] mid;
  logic [CW-1:0] lo_m1;
  logic [AW-1:0] last_addr;

  assign sum       = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = sum[AW:1];
  assign lo_m1     = lo_r - CW'(1);
  assign last_addr = (lo_r == '0) ? '0 : lo_m1[AW-1:0];

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    q_nxt     = q_r;
    rd_addr   = mid_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          q_nxt  = req.query;
          lo_nxt = '0;
          hi_nxt = key_count;
          state_nxt = (key_count == '0) ? S_ECHO : S_ADDR;
        end
      end
      S_ADDR: begin
        if (lo_r < hi_r) begin
          rd_addr   = mid;
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else begin
          rd_addr   = last_addr;
          state_nxt = S_LAST;
        end
      end
      S_CMP: begin
        if (rd_data < q_r) begin
          lo_nxt = CW'(mid_r) + CW'(1);
        end else begin
          hi_nxt = CW'(mid_r);
        end
        state_nxt = S_ADDR;
      end
      S_LAST: begin
        state_nxt = S_IDLE;
      end
      S_ECHO: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.busy   = (state_r != S_IDLE);
  assign rsp.done   = (state_r == S_LAST) || (state_r == S_ECHO);
  assign rsp.target = (state_r == S_LAST) ? rd_data : q_r;

endmodule

### hw/rtl/key_frame_seek_lookup.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall   in_kind, in_frame_number
// out_      output     out_valid/out_stall out_target_frame, out_status, out_entry_count
//
// Clear, append and unused kinds do not search; their result is registered at acceptance.
// A query makes P probes, at most ceil(log2(count+1)), of the single key memory read port,
// each probe passing through an address state and a compare state.
// A query on an empty table makes no probe.
// Reset clears the entry count and the control state; the key memory is not cleared.
// The input stalls while a query is in progress or while a held result is stalled.
module key_frame_seek_lookup #(
  parameter int MAX_KEYS = kfsl_pkg::MAX_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [kfsl_pkg::KIND_W-1:0]      in_kind,
  input  logic [kfsl_pkg::FRAME_W-1:0]     in_frame_number,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [kfsl_pkg::FRAME_W-1:0]     out_target_frame,
  output logic [kfsl_pkg::STATUS_W-1:0]    out_status,
  output logic [kfsl_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);

  logic [CW-1:0]                     count_r, count_nxt;
  logic [kfsl_pkg::FRAME_W-1:0]      last_key_r, last_key_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [kfsl_pkg::FRAME_W-1:0]      target_r, target_nxt;
  logic [kfsl_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic [kfsl_pkg::COUNT_OUT_W-1:0]  ecount_r, ecount_nxt;

  kfsl_pkg::srch_req_t          req;
  kfsl_pkg::srch_rsp_t          rsp;
  logic                         in_acc;
  logic                         wr_en;
  logic [AW-1:0]                rd_addr;
  logic [kfsl_pkg::FRAME_W-1:0] rd_data;
  logic                         is_full;
  logic                         bad_order;

  assign in_stall  = rsp.busy || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign is_full   = (count_r >= CW'(MAX_KEYS));
  assign bad_order = (count_r != '0) && (in_frame_number <= last_key_r);
  assign wr_en     = in_acc && (in_kind == kfsl_pkg::KIND_APPEND) && !is_full && !bad_order;

  assign req.start = in_acc && (in_kind == kfsl_pkg::KIND_QUERY);
  assign req.query = in_frame_number;

  always_comb begin
    count_nxt     = count_r;
    last_key_nxt  = last_key_r;
    out_valid_nxt = out_valid_r && out_stall;
    target_nxt    = target_r;
    status_nxt    = status_r;
    ecount_nxt    = ecount_r;
    if (rsp.done) begin
      out_valid_nxt = 1'b1;
      target_nxt    = rsp.target;
      status_nxt    = kfsl_pkg::ST_OK;
      ecount_nxt    = kfsl_pkg::COUNT_OUT_W'(count_r);
    end else if (in_acc && (in_kind != kfsl_pkg::KIND_QUERY)) begin
      out_valid_nxt = 1'b1;
      target_nxt    = '0;
      status_nxt    = kfsl_pkg::ST_OK;
      unique case (in_kind)
        kfsl_pkg::KIND_CLEAR: begin
          count_nxt = '0;
        end
        kfsl_pkg::KIND_APPEND: begin
          if (is_full) begin
            status_nxt = kfsl_pkg::ST_FULL;
          end else if (bad_order) begin
            status_nxt = kfsl_pkg::ST_ORDER;
          end else begin
            count_nxt    = count_r + CW'(1);
            last_key_nxt = in_frame_number;
          end
        end
        default: begin
        end
      endcase
      ecount_nxt = kfsl_pkg::COUNT_OUT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_key_r <= last_key_nxt;
    target_r   <= target_nxt;
    status_r   <= status_nxt;
    ecount_r   <= ecount_nxt;
  end

  kfsl_key_mem #(
    .DEPTH (MAX_KEYS)
  ) u_key_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (in_frame_number),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kfsl_search #(
    .MAX_KEYS (MAX_KEYS)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .key_count (count_r),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rsp       (rsp)
  );

  assign out_valid        = out_valid_r;
  assign out_target_frame = target_r;
  assign out_status       = status_r;
  assign out_entry_count  = ecount_r;

endmodule
